@@ src/cdte_pkg.sv @@
// ----------------------------------------------------------------------------
// cdte_pkg
// Types, command codes and calendar helpers for the date and time set editor.
// ----------------------------------------------------------------------------
`default_nettype none

package cdte_pkg;

    localparam int NFIELDS = 6;

    // command codes on the input channel
    typedef enum logic [2:0] {
        CMD_TICK = 3'd0,
        CMD_MODE = 3'd1,
        CMD_NEXT = 3'd2,
        CMD_UP   = 3'd3,
        CMD_DOWN = 3'd4,
        CMD_READ = 3'd5
    } t_cmd;

    // store indexes
    localparam logic [2:0] FLD_YEAR   = 3'd0;
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_DAY    = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;
    localparam logic [2:0] FLD_SECOND = 3'd5;

    localparam logic [9:0] BLINK_RESET = 10'd500;

    // one store entry, and a working copy wide enough for +1 and -1
    typedef logic [6:0]        t_entry;
    typedef logic signed [8:0] t_work;

    // days in a month; zero for a month code outside 1..12
    function automatic logic [4:0] month_days(input t_entry month,
                                              input logic [1:0] year_lo);
        logic [4:0] len;
        case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
            7'd2:    len = (year_lo == 2'd0) ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ src/clock_date_time_set_editor_core.sv @@
// ----------------------------------------------------------------------------
// clock_date_time_set_editor_core
// Date and time setting menu: show/edit mode, field select, up/down editing
// with calendar wrap, and a tick-driven blink phase.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one event per transfer: a tick,
//   a mode, next, up or down key, or a clock reading with six date and time
//   fields. Each event yields exactly one result on the output channel
//   (o_valid / i_ready): mode, selected field, blank flag, commit pulse and
//   the store as it stands after the event.
//   A result is registered at the edge after its input transfer. Throughput is
//   one event per cycle while the receiver takes results; the state update and
//   the calendar wrap are a single level of registered logic.
//   When the receiver stalls, the result register holds and o_ready follows
//   i_ready, so one new event can still enter as the held result leaves.
//   Reset (synchronous, active low) selects show mode, field 0, blink phase
//   off, tick count zero, store 00-01-01 00:00:00 and blink_ticks 500.
//   i_cfg_we writes blink_ticks from i_cfg_data; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_date_time_set_editor_core
    import cdte_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [9:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [2:0] i_cmd,
    input  wire logic [6:0] i_in_year,
    input  wire logic [3:0] i_in_month,
    input  wire logic [4:0] i_in_day,
    input  wire logic [4:0] i_in_hour,
    input  wire logic [5:0] i_in_minute,
    input  wire logic [5:0] i_in_second,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_editing,
    output logic [2:0]      o_field_sel,
    output logic            o_blank_selected,
    output logic            o_commit,
    output logic [6:0]      o_out_year,
    output logic [3:0]      o_out_month,
    output logic [4:0]      o_out_day,
    output logic [4:0]      o_out_hour,
    output logic [5:0]      o_out_minute,
    output logic [5:0]      o_out_second
);

    // state
    logic [9:0] r_blink_ticks;
    logic       r_edit, n_edit;
    logic [2:0] r_sel, n_sel;
    logic       r_blink, n_blink;
    logic [9:0] r_ticks, n_ticks;
    t_entry     r_store [NFIELDS];
    t_entry     n_store [NFIELDS];

    // result register
    logic       r_valid;
    logic       r_res_edit, r_res_blank, r_res_commit, n_commit;
    logic [2:0] r_res_sel;
    t_entry     r_res_store [NFIELDS];

    logic        w_in_xfer;
    t_work       w_work [NFIELDS];
    logic [4:0]  w_len;
    logic [10:0] w_tick_next;

    assign o_ready   = !r_valid || i_ready;
    assign w_in_xfer = i_valid && o_ready;

    always_comb begin
        n_edit      = r_edit;
        n_sel       = r_sel;
        n_blink     = r_blink;
        n_ticks     = r_ticks;
        n_commit    = 1'b0;
        n_store     = r_store;
        w_len       = 5'd0;
        w_tick_next = {1'b0, r_ticks} + 11'd1;
        for (int i = 0; i < NFIELDS; i++) begin
            w_work[i] = $signed({2'b00, r_store[i]});
        end

        case (i_cmd)
            CMD_TICK: begin
                if (w_tick_next >= {1'b0, r_blink_ticks}) begin
                    n_ticks = 10'd0;
                    n_blink = !r_blink;
                end else begin
                    n_ticks = w_tick_next[9:0];
                end
            end
            CMD_MODE: begin
                if (!r_edit) begin
                    n_edit = 1'b1;
                    n_sel  = FLD_YEAR;
                end else begin
                    n_edit   = 1'b0;
                    n_commit = 1'b1;
                end
            end
            CMD_NEXT: begin
                if (r_edit) begin
                    n_sel = (r_sel >= FLD_SECOND) ? FLD_YEAR : r_sel + 3'd1;
                end
            end
            CMD_UP: begin
                if (r_edit) begin
                    for (int i = 0; i < NFIELDS; i++) begin
                        if (3'(i) == r_sel) w_work[i] = w_work[i] + 9'sd1;
                    end
                    // wrap every field above its range back to its low end; the day only for a month in 1..12
                    if (w_work[FLD_YEAR] > 9'sd99)   w_work[FLD_YEAR]  = 9'sd0;
                    if (w_work[FLD_MONTH] > 9'sd12)  w_work[FLD_MONTH] = 9'sd1;
                    w_len = month_days(w_work[FLD_MONTH][6:0], w_work[FLD_YEAR][1:0]);
                    if (w_len != 5'd0 && w_work[FLD_DAY] > $signed({4'b0000, w_len}))
                        w_work[FLD_DAY] = 9'sd1;
                    if (w_work[FLD_HOUR] > 9'sd23)   w_work[FLD_HOUR]   = 9'sd0;
                    if (w_work[FLD_MINUTE] > 9'sd59) w_work[FLD_MINUTE] = 9'sd0;
                    if (w_work[FLD_SECOND] > 9'sd59) w_work[FLD_SECOND] = 9'sd0;
                    for (int i = 0; i < NFIELDS; i++) n_store[i] = w_work[i][6:0];
                end
            end
            CMD_DOWN: begin
                if (r_edit) begin
                    for (int i = 0; i < NFIELDS; i++) begin
                        if (3'(i) == r_sel) w_work[i] = w_work[i] - 9'sd1;
                    end
                    if (w_work[FLD_YEAR] < 9'sd0)  w_work[FLD_YEAR]  = 9'sd99;
                    if (w_work[FLD_MONTH] < 9'sd1) w_work[FLD_MONTH] = 9'sd12;
                    w_len = month_days(w_work[FLD_MONTH][6:0], w_work[FLD_YEAR][1:0]);
                    if (w_len != 5'd0) begin
                        if (w_work[FLD_DAY] < 9'sd1)
                            w_work[FLD_DAY] = $signed({4'b0000, w_len});
                        if (w_work[FLD_DAY] > $signed({4'b0000, w_len}))
                            w_work[FLD_DAY] = 9'sd1;
                    end
                    if (w_work[FLD_HOUR] < 9'sd0)   w_work[FLD_HOUR]   = 9'sd23;
                    if (w_work[FLD_MINUTE] < 9'sd0) w_work[FLD_MINUTE] = 9'sd59;
                    if (w_work[FLD_SECOND] < 9'sd0) w_work[FLD_SECOND] = 9'sd59;
                    for (int i = 0; i < NFIELDS; i++) n_store[i] = w_work[i][6:0];
                end
            end
            CMD_READ: begin
                // readings are dropped while editing
                if (!r_edit) begin
                    n_store[FLD_YEAR]   = i_in_year;
                    n_store[FLD_MONTH]  = {3'b000, i_in_month};
                    n_store[FLD_DAY]    = {2'b00, i_in_day};
                    n_store[FLD_HOUR]   = {2'b00, i_in_hour};
                    n_store[FLD_MINUTE] = {1'b0, i_in_minute};
                    n_store[FLD_SECOND] = {1'b0, i_in_second};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_ticks     <= BLINK_RESET;
            r_edit            <= 1'b0;
            r_sel             <= FLD_YEAR;
            r_blink           <= 1'b0;
            r_ticks           <= 10'd0;
            r_store[FLD_YEAR]   <= 7'd0;
            r_store[FLD_MONTH]  <= 7'd1;
            r_store[FLD_DAY]    <= 7'd1;
            r_store[FLD_HOUR]   <= 7'd0;
            r_store[FLD_MINUTE] <= 7'd0;
            r_store[FLD_SECOND] <= 7'd0;
            r_valid           <= 1'b0;
        end else begin
            if (i_cfg_we) r_blink_ticks <= i_cfg_data;
            if (w_in_xfer) begin
                r_edit  <= n_edit;
                r_sel   <= n_sel;
                r_blink <= n_blink;
                r_ticks <= n_ticks;
                r_store <= n_store;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_res_edit   <= n_edit;
            r_res_sel    <= n_sel;
            r_res_blank  <= n_edit && n_blink;
            r_res_commit <= n_commit;
            r_res_store  <= n_store;
        end
    end

    assign o_valid          = r_valid;
    assign o_editing        = r_res_edit;
    assign o_field_sel      = r_res_sel;
    assign o_blank_selected = r_res_blank;
    assign o_commit         = r_res_commit;
    assign o_out_year       = r_res_store[FLD_YEAR];
    assign o_out_month      = r_res_store[FLD_MONTH][3:0];
    assign o_out_day        = r_res_store[FLD_DAY][4:0];
    assign o_out_hour       = r_res_store[FLD_HOUR][4:0];
    assign o_out_minute     = r_res_store[FLD_MINUTE][5:0];
    assign o_out_second     = r_res_store[FLD_SECOND][5:0];

    // commit only on the transfer that leaves edit mode
    a_commit_leaves_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_commit) |-> !o_editing)
        else $error("commit with edit mode still set");

    a_blank_needs_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_blank_selected) |-> o_editing)
        else $error("blank flag outside edit mode");

    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel <= FLD_SECOND)
        else $error("selected field out of range");

    a_mode_follows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (o_editing == r_edit && o_field_sel == r_sel))
        else $error("result mode differs from state");

endmodule

`default_nettype wire
